// ----- design/vts_pkg.sv -----
// Shared types and constants for the trilinear volume sampler.
package vts_pkg;

  localparam int MAX_DIM_DEF   = 64;
  localparam int FRAC_BITS_DEF = 8;
  localparam int SIZE_W        = 7;
  localparam int SIZE_RESET    = 64;
  localparam int VAL_W         = 16;
  localparam int POS_W         = 16;
  localparam int OUT_DEPTH     = 16;
  localparam int CORNERS       = 8;
  localparam int CORNER_W      = 3;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_TRI   = 2'd1,
    ACT_NEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    LK_FIRST  = 2'd0,
    LK_SECOND = 2'd1,
    LK_PASS   = 2'd2
  } lerp_kind_t;

  typedef struct packed {
    logic       vld;
    lerp_kind_t kind;
  } lerp_ctl_t;

endpackage

// ----- design/vts_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
module vts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/vts_lerp.sv -----
// Pipelined linear interpolation unit: one weighted operand per cycle, three stages.
module vts_lerp #(
  parameter int FRAC_BITS = vts_pkg::FRAC_BITS_DEF,
  parameter int TAG_W     = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vts_pkg::lerp_ctl_t               in_ctl,
  input  logic signed [vts_pkg::VAL_W-1:0] in_val,
  input  logic [FRAC_BITS-1:0]             in_frac,
  input  logic [TAG_W-1:0]                 in_tag,
  output logic                             out_vld,
  output logic signed [vts_pkg::VAL_W-1:0] out_val,
  output logic [TAG_W-1:0]                 out_tag
);
  import vts_pkg::*;

  localparam int W_W = FRAC_BITS + 2;
  localparam int P_W = VAL_W + W_W;
  localparam logic [W_W-1:0] ONE = W_W'(1) << FRAC_BITS;
  localparam logic signed [P_W-1:0] BIAS = P_W'((64'd1 << FRAC_BITS) - 64'd1);

  logic [W_W-1:0]          wgt;
  logic signed [P_W-1:0]   prod_nxt;

  logic                    s1_vld_r;
  lerp_kind_t              s1_kind_r;
  logic signed [P_W-1:0]   s1_prod_r;
  logic [TAG_W-1:0]        s1_tag_r;

  logic signed [P_W-1:0]   hold_r;
  logic signed [P_W-1:0]   addend;
  logic                    s2_vld_r;
  logic signed [P_W-1:0]   s2_sum_r;
  logic [TAG_W-1:0]        s2_tag_r;

  logic signed [P_W-1:0]   biased;
  logic signed [P_W-1:0]   quot;
  logic                    out_vld_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic [TAG_W-1:0]        out_tag_r;

  // The first operand of a pair carries 1 - f, the second f; a pass-through
  // item is weighted by exactly one so it leaves unchanged.
  always_comb begin
    case (in_ctl.kind)
      LK_FIRST:  wgt = ONE - W_W'(in_frac);
      LK_SECOND: wgt = W_W'(in_frac);
      default:   wgt = ONE;
    endcase
  end

  assign prod_nxt = in_val * $signed(wgt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_ctl.vld;
      s2_vld_r  <= s1_vld_r && (s1_kind_r != LK_FIRST);
      out_vld_r <= s2_vld_r;
    end
  end

  assign addend = (s1_kind_r == LK_PASS) ? P_W'(0) : hold_r;

  // Division by 2^F truncating toward zero.
  assign biased = s2_sum_r + (s2_sum_r[P_W-1] ? BIAS : P_W'(0));
  assign quot   = biased >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    s1_kind_r <= in_ctl.kind;
    s1_prod_r <= prod_nxt;
    s1_tag_r  <= in_tag;
    if (s1_vld_r && (s1_kind_r == LK_FIRST)) begin
      hold_r <= s1_prod_r;
    end
    s2_sum_r  <= addend + s1_prod_r;
    s2_tag_r  <= s1_tag_r;
    out_val_r <= quot[VAL_W-1:0];
    out_tag_r <= s2_tag_r;
  end

  assign out_vld = out_vld_r;
  assign out_val = out_val_r;
  assign out_tag = out_tag_r;

endmodule

// ----- design/volume_trilinear_sampler.sv -----
// Top level of the trilinear volume sampler: voxel memory, corner sequencer and output queue.
//
// Input stream: in_tuser selects the action (write voxel, trilinear sample, nearest
// sample); in_tdata carries the three fixed-point coordinates and the write value.
// Result stream: one out_tdata transaction per sample action, none for a write.
// Configuration: cfg_index/cfg_data set the volume sizes; cfg_ready is always high.
// A trilinear sample walks its eight neighbors through the single voxel memory port,
// one read per cycle, and holds the port until its last neighbor is issued; a write
// or a nearest sample takes a single port slot, so those sustain one transaction per cycle
// while in_tready is high. From acceptance a sample passes the input stage, the corner
// issue stage and the registered memory read with its read alignment stage, then the
// three interpolation stages (x, y, z) and the output queue.
// Up to 16 sample results may be outstanding; when the receiver stalls they collect
// in the output queue and in_tready drops once the queue could overflow, while the
// pipeline itself never stops.
// Reset returns the sizes to 64 and empties the pipeline and queue; the voxel memory
// is not cleared and must be written before it is read.
module volume_trilinear_sampler #(
  parameter int MAX_DIM   = vts_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = vts_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,  // pos_x, pos_y, pos_z, write_value
  input  logic [1:0]                    in_tuser,  // action
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [vts_pkg::VAL_W-1:0]     out_tdata, // sample
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [vts_pkg::SIZE_W-1:0]    cfg_data
);
  import vts_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int EXT_W  = POS_W + 2;
  localparam int CW     = EXT_W - FRAC_BITS;
  localparam int SUM_W  = IDX_W + 2 * DIM_W + 1;
  localparam int PTR_W  = $clog2(OUT_DEPTH);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int TAG_X  = 3 + 2 * FRAC_BITS;
  localparam int TAG_Y  = 2 + FRAC_BITS;
  localparam logic [DIM_W-1:0] SIZE_RST =
    DIM_W'((SIZE_RESET > MAX_DIM) ? MAX_DIM : SIZE_RESET);
  localparam logic signed [EXT_W-1:0] HALF = EXT_W'(1) << (FRAC_BITS - 1);

  function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(v);
  endfunction

  // Integer grid coordinate: floor of the position, rounded for nearest sampling.
  function automatic logic signed [CW-1:0] grid(input logic signed [POS_W-1:0] p,
                                                input logic rnd);
    logic signed [EXT_W-1:0] ext;
    logic signed [EXT_W-1:0] sh;
    ext = EXT_W'(p);
    if (rnd) begin
      ext = ext + HALF;
    end
    sh = ext >>> FRAC_BITS;
    return sh[CW-1:0];
  endfunction

  function automatic logic in_rng(input logic signed [CW-1:0] c,
                                  input logic [DIM_W-1:0] s);
    logic [CW-2:0] mag;
    mag = c[CW-2:0];
    return !c[CW-1] && (mag < s);
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(input logic signed [CW-1:0] c);
    logic [CW-2:0] mag;
    mag = c[CW-2:0];
    return IDX_W'(mag);
  endfunction

  // Volume sizes, held as effective values.
  logic [DIM_W-1:0]     sx_r, sy_r, sz_r;
  logic [2*DIM_W-1:0]   sxsy_r;

  // Input stage.
  logic                    a_vld_r;
  action_t                 a_act_r;
  logic signed [POS_W-1:0] a_px_r, a_py_r, a_pz_r;
  logic [VAL_W-1:0]        a_wval_r;
  logic                    a_rnd;
  logic signed [CW-1:0]    x_lo, y_lo, z_lo, x_hi, y_hi, z_hi;
  logic                    in_fire, a_move;

  // Corner issue stage.
  logic                    b_vld_r;
  action_t                 b_act_r;
  logic [CORNER_W-1:0]     b_cnt_r;
  logic [IDX_W-1:0]        b_xl_r, b_xh_r, b_yl_r, b_yh_r, b_zl_r, b_zh_r;
  logic [1:0]              b_okx_r, b_oky_r, b_okz_r;
  logic [FRAC_BITS-1:0]    b_fx_r, b_fy_r, b_fz_r;
  logic [VAL_W-1:0]        b_wval_r;
  logic                    b_last, b_take, b_ok, b_sample;
  logic [IDX_W-1:0]        xi, yi, zi;
  logic [IDX_W+DIM_W-1:0]   prod_xy;
  logic [IDX_W+2*DIM_W-1:0] prod_z;
  logic [SUM_W-1:0]        addr_full;
  logic                    mem_en, mem_we;
  logic [VAL_W-1:0]        mem_rdata;

  // Read data alignment stage.
  logic                    c_vld_r, c_tri_r, c_zero_r;
  logic [CORNER_W-1:0]     c_k_r;
  logic [FRAC_BITS-1:0]    c_fx_r, c_fy_r, c_fz_r;

  // Interpolation chain.
  lerp_ctl_t               x_ctl, y_ctl, z_ctl;
  logic signed [VAL_W-1:0] x_in, xo_val, yo_val, zo_val;
  logic [TAG_X-1:0]        x_tag, xo_tag;
  logic [TAG_Y-1:0]        y_tag, yo_tag;
  logic                    xo_vld, yo_vld, zo_vld, zo_tri;
  logic                    xo_tri, xo_k1, xo_k2, yo_tri, yo_k2;
  logic [FRAC_BITS-1:0]    xo_fy, xo_fz, yo_fz;
  logic [VAL_W-1:0]        final_val;

  // Output queue.
  logic [VAL_W-1:0]        q_mem_r [OUT_DEPTH];
  logic [PTR_W-1:0]        q_wr_r, q_rd_r;
  logic [CNT_W-1:0]        q_cnt_r, q_cnt_nxt;
  logic [CNT_W-1:0]        pend_r, pend_nxt;
  logic                    q_push, q_pop, in_sample;

  // ---------------------------------------------------------------- configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= SIZE_RST;
      sy_r <= SIZE_RST;
      sz_r <= SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIZE_X: sx_r <= eff_size(cfg_data);
        REG_SIZE_Y: sy_r <= eff_size(cfg_data);
        REG_SIZE_Z: sz_r <= eff_size(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sxsy_r <= sx_r * sy_r;
  end

  // ---------------------------------------------------------------- input stage
  assign in_sample = (in_tuser == ACT_TRI) || (in_tuser == ACT_NEAR);
  assign in_fire   = in_tvalid && in_tready;
  assign a_move    = a_vld_r && b_take;
  assign in_tready = (!a_vld_r || b_take) && (pend_r < CNT_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_fire) begin
      a_vld_r <= 1'b1;
    end else if (a_move) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_act_r  <= action_t'(in_tuser);
      a_px_r   <= in_tdata[15:0];
      a_py_r   <= in_tdata[31:16];
      a_pz_r   <= in_tdata[47:32];
      a_wval_r <= in_tdata[63:48];
    end
  end

  assign a_rnd = (a_act_r == ACT_NEAR);
  assign x_lo  = grid(a_px_r, a_rnd);
  assign y_lo  = grid(a_py_r, a_rnd);
  assign z_lo  = grid(a_pz_r, a_rnd);
  assign x_hi  = x_lo + CW'(1);
  assign y_hi  = y_lo + CW'(1);
  assign z_hi  = z_lo + CW'(1);

  // ---------------------------------------------------------------- corner issue
  // Corner bits: bit 0 steps x, bit 1 steps y, bit 2 steps z.
  assign b_last = (b_act_r != ACT_TRI) || (b_cnt_r == CORNER_W'(CORNERS - 1));
  assign b_take = !b_vld_r || b_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      b_cnt_r <= '0;
    end else if (b_take) begin
      b_vld_r <= a_vld_r;
      b_cnt_r <= '0;
    end else begin
      b_cnt_r <= b_cnt_r + CORNER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      b_act_r  <= a_act_r;
      b_xl_r   <= to_idx(x_lo);
      b_xh_r   <= to_idx(x_hi);
      b_yl_r   <= to_idx(y_lo);
      b_yh_r   <= to_idx(y_hi);
      b_zl_r   <= to_idx(z_lo);
      b_zh_r   <= to_idx(z_hi);
      b_okx_r  <= {in_rng(x_hi, sx_r), in_rng(x_lo, sx_r)};
      b_oky_r  <= {in_rng(y_hi, sy_r), in_rng(y_lo, sy_r)};
      b_okz_r  <= {in_rng(z_hi, sz_r), in_rng(z_lo, sz_r)};
      b_fx_r   <= a_px_r[FRAC_BITS-1:0];
      b_fy_r   <= a_py_r[FRAC_BITS-1:0];
      b_fz_r   <= a_pz_r[FRAC_BITS-1:0];
      b_wval_r <= a_wval_r;
    end
  end

  assign xi   = b_cnt_r[0] ? b_xh_r : b_xl_r;
  assign yi   = b_cnt_r[1] ? b_yh_r : b_yl_r;
  assign zi   = b_cnt_r[2] ? b_zh_r : b_zl_r;
  assign b_ok = b_okx_r[b_cnt_r[0]] && b_oky_r[b_cnt_r[1]] && b_okz_r[b_cnt_r[2]];

  assign prod_xy   = xi * sy_r;
  assign prod_z    = zi * sxsy_r;
  assign addr_full = SUM_W'(yi) + SUM_W'(prod_xy) + SUM_W'(prod_z);

  always_comb begin
    b_sample = 1'b0;
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    case (b_act_r) inside
      ACT_WRITE: begin
        mem_en = b_vld_r && b_ok;
        mem_we = 1'b1;
      end
      ACT_TRI, ACT_NEAR: begin
        b_sample = 1'b1;
        mem_en   = b_vld_r && b_ok;
      end
      default: ;
    endcase
  end

  vts_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_voxels (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (addr_full[ADDR_W-1:0]),
    .wdata (b_wval_r),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------- read alignment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r && b_sample;
    end
  end

  always_ff @(posedge clk) begin
    c_tri_r  <= (b_act_r == ACT_TRI);
    c_zero_r <= !b_ok;
    c_k_r    <= b_cnt_r;
    c_fx_r   <= b_fx_r;
    c_fy_r   <= b_fy_r;
    c_fz_r   <= b_fz_r;
  end

  // ---------------------------------------------------------------- interpolation
  // Neighbors outside the volume read as zero. A nearest sample passes through
  // all three units unchanged, which keeps results in order.
  assign x_in       = c_zero_r ? VAL_W'(0) : mem_rdata;
  assign x_ctl.vld  = c_vld_r;
  assign x_ctl.kind = !c_tri_r ? LK_PASS : (c_k_r[0] ? LK_SECOND : LK_FIRST);
  assign x_tag      = {c_tri_r, c_k_r[2], c_k_r[1], c_fz_r, c_fy_r};

  vts_lerp #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (TAG_X)
  ) u_lerp_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (x_ctl),
    .in_val  (x_in),
    .in_frac (c_fx_r),
    .in_tag  (x_tag),
    .out_vld (xo_vld),
    .out_val (xo_val),
    .out_tag (xo_tag)
  );

  assign {xo_tri, xo_k2, xo_k1, xo_fz, xo_fy} = xo_tag;
  assign y_ctl.vld  = xo_vld;
  assign y_ctl.kind = !xo_tri ? LK_PASS : (xo_k1 ? LK_SECOND : LK_FIRST);
  assign y_tag      = {xo_tri, xo_k2, xo_fz};

  vts_lerp #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (TAG_Y)
  ) u_lerp_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (y_ctl),
    .in_val  (xo_val),
    .in_frac (xo_fy),
    .in_tag  (y_tag),
    .out_vld (yo_vld),
    .out_val (yo_val),
    .out_tag (yo_tag)
  );

  assign {yo_tri, yo_k2, yo_fz} = yo_tag;
  assign z_ctl.vld  = yo_vld;
  assign z_ctl.kind = !yo_tri ? LK_PASS : (yo_k2 ? LK_SECOND : LK_FIRST);

  vts_lerp #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (1)
  ) u_lerp_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (z_ctl),
    .in_val  (yo_val),
    .in_frac (yo_fz),
    .in_tag  (yo_tri),
    .out_vld (zo_vld),
    .out_val (zo_val),
    .out_tag (zo_tri)
  );

  // Only the trilinear result is clamped at zero.
  assign final_val = (zo_tri && zo_val[VAL_W-1]) ? VAL_W'(0) : zo_val;

  // ---------------------------------------------------------------- output queue
  assign q_push     = zo_vld;
  assign q_pop      = out_tvalid && out_tready;
  assign out_tvalid = (q_cnt_r != '0);
  assign out_tdata  = q_mem_r[q_rd_r];

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (q_push && !q_pop) begin
      q_cnt_nxt = q_cnt_r + CNT_W'(1);
    end else if (q_pop && !q_push) begin
      q_cnt_nxt = q_cnt_r - CNT_W'(1);
    end
  end

  // Every sample transaction holds a queue slot from acceptance until delivery.
  always_comb begin
    pend_nxt = pend_r;
    if ((in_fire && in_sample) && !q_pop) begin
      pend_nxt = pend_r + CNT_W'(1);
    end else if (q_pop && !(in_fire && in_sample)) begin
      pend_nxt = pend_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
      pend_r  <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      pend_r  <= pend_nxt;
      if (q_push) begin
        q_wr_r <= q_wr_r + PTR_W'(1);
      end
      if (q_pop) begin
        q_rd_r <= q_rd_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[q_wr_r] <= final_val;
    end
  end

endmodule

// ----- design/vts_checker.sv -----
// Port-level checker for the trilinear volume sampler and its bind statement.
module vts_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [1:0]                in_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [vts_pkg::VAL_W-1:0] out_tdata
);
  import vts_pkg::*;

  logic [7:0] outst_r;
  logic       smp_in, smp_out;

  assign smp_in  = in_tvalid && in_tready &&
                   ((in_tuser == ACT_TRI) || (in_tuser == ACT_NEAR));
  assign smp_out = out_tvalid && out_tready;

  // Sample transactions accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= '0;
    end else if (smp_in && !smp_out) begin
      outst_r <= outst_r + 8'd1;
    end else if (smp_out && !smp_in) begin
      outst_r <= outst_r - 8'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> outst_r != 8'd0)
    else $error("result offered with no sample outstanding");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> outst_r != 8'd0)
    else $error("input back-pressured with no sample outstanding");

endmodule

bind volume_trilinear_sampler vts_checker u_vts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
